### src/tlph_pkg.sv
// tlph_pkg: shared types and constants for the two-level perfect hash table.
// Holds opcode, status and register index codes, the control state type and defaults.
// No dependencies.
package tlph_pkg;

   localparam int MAX_BUCKETS_DEF = 256;
   localparam int SLOT_WORDS_DEF  = 4096;
   localparam int KEY_BITS_DEF    = 16;

   localparam int DIV_BITS = 32;

   localparam logic [2:0] OP_CLEAR  = 3'd0;
   localparam logic [2:0] OP_COUNT  = 3'd1;
   localparam logic [2:0] OP_SET    = 3'd2;
   localparam logic [2:0] OP_INSERT = 3'd3;
   localparam logic [2:0] OP_LOOKUP = 3'd4;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_EMPTY = 2'd2;
   localparam logic [1:0] ST_RANGE = 2'd3;

   localparam logic [1:0] CSR_FIRST_MULT   = 2'd0;
   localparam logic [1:0] CSR_FIRST_MOD    = 2'd1;
   localparam logic [1:0] CSR_BUCKET_TOTAL = 2'd2;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SWEEP,
      S_MUL1,
      S_DIVA,
      S_DIVB,
      S_BRD,
      S_BUCK,
      S_MUL2,
      S_DIVC,
      S_DIVD,
      S_SRD,
      S_SLOT,
      S_SETCHK,
      S_SETRD,
      S_SETSQ,
      S_SETWR
   } state_type;

endpackage

### src/tlph_rem.sv
// tlph_rem: iterative remainder unit, one dividend bit per cycle.
// A zero divisor returns the dividend unreduced. Uses tlph_pkg for the divisor width.
module tlph_rem
   import tlph_pkg::*;
#(
   parameter int PROD_BITS = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [PROD_BITS-1:0] dividend,
   input  logic [DIV_BITS-1:0]  divisor,
   output logic                 busy,
   output logic                 done,
   output logic [PROD_BITS-1:0] result
);

   localparam int CW = $clog2(PROD_BITS + 1);

   logic                 busy_ff;
   logic [CW-1:0]        cnt_ff;
   logic [DIV_BITS:0]    rem_ff;
   logic [PROD_BITS-1:0] dq_ff;
   logic [PROD_BITS-1:0] orig_ff;
   logic [DIV_BITS-1:0]  d_ff;
   logic                 keep_ff;
   logic [DIV_BITS:0]    trial;
   logic                 step;

   assign step  = busy_ff && (cnt_ff != '0);
   assign done  = busy_ff && (cnt_ff == '0);
   assign busy  = busy_ff;
   assign trial = {rem_ff[DIV_BITS-1:0], dq_ff[PROD_BITS-1]};
   assign result = keep_ff ? orig_ff : PROD_BITS'(rem_ff[DIV_BITS-1:0]);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else if (start) begin
         busy_ff <= 1'b1;
      end else if (done) begin
         busy_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         cnt_ff  <= CW'(PROD_BITS);
         rem_ff  <= '0;
         dq_ff   <= dividend;
         orig_ff <= dividend;
         d_ff    <= divisor;
         keep_ff <= (divisor == '0);
      end else if (step) begin
         cnt_ff <= cnt_ff - 1'b1;
         dq_ff  <= {dq_ff[PROD_BITS-2:0], 1'b0};
         if (trial >= {1'b0, d_ff}) begin
            rem_ff <= trial - {1'b0, d_ff};
         end else begin
            rem_ff <= trial;
         end
      end
   end

endmodule

### src/two_level_perfect_hash_table_top.sv
// two_level_perfect_hash_table_top: control, bucket memory and slot memory.
// Depends on tlph_pkg and tlph_rem.
//
//  channel   direction  ports                                  contents
//  req       in         req_tvalid/tready/tdata/tuser          one request
//  rsp       out        rsp_tvalid/tready/tdata/tuser          one result per request
//  csr       in         csr_we/csr_index/csr_wdata             register write
//
// One request at a time. Count runs a multiply, two remainder steps and a bucket read;
// insert and lookup add a second multiply, two more remainder steps and a slot read;
// set bucket checks the range and, when in range, reads the count, squares it and writes
// the bucket entry. Clear sweeps through both memories.
// After reset the same sweep runs before req_tready rises.
// A finished result waits in the output register while the next request is taken.
module two_level_perfect_hash_table_top
   import tlph_pkg::*;
#(
   parameter int MAX_BUCKETS = MAX_BUCKETS_DEF,
   parameter int SLOT_WORDS  = SLOT_WORDS_DEF,
   parameter int KEY_BITS    = KEY_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [55:0] req_tdata,  // key, bucket_sel, second_mult, second_mod
   input  logic [2:0]  req_tuser,  // op
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,  // hit, collided, bucket_out, slot_out, square_total, 0
   output logic [1:0]  rsp_tuser,  // status
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   localparam int BW    = $clog2(MAX_BUCKETS);
   localparam int SW    = $clog2(SLOT_WORDS);
   localparam int NFW   = $clog2(SLOT_WORDS + 1);
   localparam int PW    = 16 + KEY_BITS;
   localparam int ETW   = $clog2(MAX_BUCKETS + 1);
   localparam int LEN   = (MAX_BUCKETS > SLOT_WORDS) ? MAX_BUCKETS : SLOT_WORDS;
   localparam int IW    = $clog2(LEN + 1);
   localparam int SUMW  = ((PW > NFW) ? PW : NFW) + 1;
   localparam int BMW   = 48 + NFW;

   state_type state_ff, state_in;

   logic [15:0] first_mult_ff, first_mod_ff;
   logic [8:0]  bucket_total_ff;

   logic [2:0]          op_ff;
   logic [KEY_BITS-1:0] key_ff;
   logic [7:0]          sel_ff;
   logic [15:0]         m2_ff, d2_ff;

   logic [NFW-1:0]  nf_ff;
   logic [31:0]     sqsum_ff;
   logic [IW-1:0]   idx_ff;
   logic            pend_ff;
   logic            swp_ff;
   logic [BW-1:0]   swa_ff;

   logic [PW-1:0]   prod_ff, v_ff;
   logic [BW-1:0]   b_ff;
   logic [15:0]     c_ff, bm_ff, bd_ff;
   logic [NFW-1:0]  base_ff;
   logic [31:0]     sq_ff;
   logic [SW-1:0]   slot_ff;

   logic [7:0]      bout_ff;
   logic [11:0]     sout_ff;
   logic [1:0]      status_ff;

   logic            rsp_tvalid_ff;
   logic [55:0]     rsp_tdata_ff;
   logic [1:0]      rsp_tuser_ff;

   logic [BMW-1:0]      bmem [MAX_BUCKETS];
   logic [BMW-1:0]      bq_ff;
   logic [KEY_BITS:0]   smem [SLOT_WORDS];
   logic [KEY_BITS:0]   sq_rd_ff;

   logic            req_fire, out_free;
   logic [ETW-1:0]  eff;
   logic            div_start, div_busy, div_done;
   logic [PW-1:0]   div_a, div_res;
   logic [DIV_BITS-1:0] div_d;
   logic [BW-1:0]   bra, bwa;
   logic            bwe;
   logic [BMW-1:0]  bwd;
   logic            swe;
   logic [SW-1:0]   swa;
   logic [KEY_BITS:0] swd;
   logic [15:0]     bcnt;
   logic [32:0]     sq_next;
   logic [32:0]     need_sum;
   logic [SUMW-1:0] slot_sum;
   logic            in_bk, in_slot;
   logic            slot_match, hit_c, coll_c;

   assign req_fire = req_tvalid && req_tready;
   assign out_free = !rsp_tvalid_ff || rsp_tready;
   assign eff = ((bucket_total_ff == '0) || (32'(bucket_total_ff) > MAX_BUCKETS))
                ? ETW'(MAX_BUCKETS) : ETW'(bucket_total_ff);
   assign bcnt     = bq_ff[15:0];
   assign sq_next  = 33'(sqsum_ff) + 33'({bcnt, 1'b1});
   assign need_sum = 33'(nf_ff) + 33'(sq_ff);
   assign slot_sum = SUMW'(base_ff) + SUMW'(div_res);
   assign in_bk    = 32'(idx_ff) < MAX_BUCKETS;
   assign in_slot  = 32'(idx_ff) < SLOT_WORDS;

   assign slot_match = (sq_rd_ff[KEY_BITS-1:0] == key_ff);
   assign hit_c  = (op_ff == OP_LOOKUP) && (status_ff == ST_OK) && sq_rd_ff[KEY_BITS]
                   && slot_match;
   assign coll_c = (op_ff == OP_INSERT) && (status_ff == ST_OK) && sq_rd_ff[KEY_BITS]
                   && !slot_match;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         first_mult_ff   <= 16'd1;
         first_mod_ff    <= 16'd1;
         bucket_total_ff <= 9'd256;
      end else if (csr_we) begin
         case (csr_index)
            CSR_FIRST_MULT:   first_mult_ff   <= csr_wdata;
            CSR_FIRST_MOD:    first_mod_ff    <= csr_wdata;
            CSR_BUCKET_TOTAL: bucket_total_ff <= csr_wdata[8:0];
            default: ;
         endcase
      end
   end

   tlph_rem #(.PROD_BITS(PW)) u_rem (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_a),
      .divisor  (div_d),
      .busy     (div_busy),
      .done     (div_done),
      .result   (div_res)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               case (req_tuser)
                  OP_CLEAR:                     state_in = S_SWEEP;
                  OP_COUNT, OP_INSERT, OP_LOOKUP: state_in = S_MUL1;
                  OP_SET:                       state_in = S_SETCHK;
                  default:                      state_in = S_SLOT;
               endcase
            end
         end
         S_SWEEP: if (idx_ff == IW'(LEN)) state_in = pend_ff ? S_SLOT : S_IDLE;
         S_MUL1:  state_in = S_DIVA;
         S_DIVA:  if (div_done) state_in = S_DIVB;
         S_DIVB:  if (div_done) state_in = S_BRD;
         S_BRD:   state_in = S_BUCK;
         S_BUCK: begin
            if (op_ff == OP_COUNT || bcnt == '0) state_in = S_SLOT;
            else state_in = S_MUL2;
         end
         S_MUL2:  state_in = S_DIVC;
         S_DIVC:  if (div_done) state_in = S_DIVD;
         S_DIVD: begin
            if (div_done) state_in = S_SRD;
         end
         S_SRD:   state_in = S_SLOT;
         S_SLOT: begin
            // finishing state: hold until the output register is free
            if (out_free) state_in = S_IDLE;
         end
         S_SETCHK: state_in = (32'(sel_ff) >= 32'(eff)) ? S_SLOT : S_SETRD;
         S_SETRD:  state_in = S_SETSQ;
         S_SETSQ:  state_in = S_SETWR;
         S_SETWR:  state_in = S_SLOT;
         default:  state_in = S_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      req_tready = (state_ff == S_IDLE);
      div_start  = 1'b0;
      div_a      = prod_ff;
      div_d      = DIV_BITS'(first_mod_ff);
      case (state_ff)
         S_DIVA: begin
            div_start = !div_busy;
         end
         S_DIVB: begin
            div_start = !div_busy;
            div_a     = v_ff;
            div_d     = DIV_BITS'(eff);
         end
         S_DIVC: begin
            div_start = !div_busy;
            div_d     = DIV_BITS'(bd_ff);
         end
         S_DIVD: begin
            div_start = !div_busy;
            div_a     = v_ff;
            div_d     = sq_ff;
         end
         default: ;
      endcase

      bra = b_ff;
      if (state_ff == S_SWEEP) bra = BW'(idx_ff);
      else if (state_ff == S_SETCHK) bra = BW'(sel_ff);

      bwe = 1'b0;
      bwa = b_ff;
      bwd = {bq_ff[BMW-1:16], bcnt + 16'd1};
      case (state_ff)
         S_SWEEP: begin
            bwe = swp_ff;
            bwa = swa_ff;
            bwd = {bq_ff[BMW-1:16], 16'd0};
         end
         S_BUCK: bwe = (op_ff == OP_COUNT) && (bcnt != 16'hFFFF);
         S_SETWR: begin
            bwe = (need_sum <= 33'(SLOT_WORDS));
            bwa = BW'(sel_ff);
            bwd = {nf_ff, d2_ff, m2_ff, c_ff};
         end
         default: ;
      endcase

      swe = 1'b0;
      swa = slot_ff;
      swd = {1'b1, key_ff};
      if (state_ff == S_SWEEP) begin
         swe = in_slot;
         swa = SW'(idx_ff);
         swd = '0;
      end else if (state_ff == S_SLOT && op_ff == OP_INSERT && status_ff == ST_OK
                   && pend_ff && out_free) begin
         swe = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_SWEEP;
      end else begin
         state_ff <= state_in;
      end
   end

   // memories
   always_ff @(posedge clock) begin
      if (bwe) bmem[bwa] <= bwd;
      bq_ff <= bmem[bra];
   end

   always_ff @(posedge clock) begin
      if (swe) smem[swa] <= swd;
      sq_rd_ff <= smem[slot_ff];
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         pend_ff  <= 1'b0;
         swp_ff   <= 1'b0;
         nf_ff    <= '0;
         sqsum_ff <= '0;
      end else begin
         swp_ff <= (state_ff == S_SWEEP) && in_bk;
         case (state_ff)
            S_IDLE: begin
               if (req_fire) begin
                  idx_ff  <= '0;
                  pend_ff <= 1'b1;
                  if (req_tuser == OP_CLEAR) begin
                     nf_ff    <= '0;
                     sqsum_ff <= '0;
                  end
               end
            end
            S_SWEEP: if (idx_ff != IW'(LEN)) idx_ff <= idx_ff + 1'b1;
            S_BUCK: begin
               if (op_ff == OP_COUNT && bcnt != 16'hFFFF) begin
                  sqsum_ff <= sq_next[32] ? 32'hFFFF_FFFF : sq_next[31:0];
               end
            end
            S_SETWR: begin
               if (need_sum <= 33'(SLOT_WORDS)) nf_ff <= NFW'(need_sum);
            end
            S_SLOT: if (out_free) pend_ff <= 1'b0;
            default: ;
         endcase
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               op_ff     <= req_tuser;
               key_ff    <= KEY_BITS'(req_tdata[15:0]);
               sel_ff    <= req_tdata[23:16];
               m2_ff     <= req_tdata[39:24];
               d2_ff     <= req_tdata[55:40];
               bout_ff   <= '0;
               sout_ff   <= '0;
               status_ff <= ST_OK;
            end
         end
         S_SWEEP: swa_ff <= BW'(idx_ff);
         S_MUL1:  prod_ff <= PW'(first_mult_ff) * PW'(key_ff);
         S_DIVA:  if (div_done) v_ff <= div_res;
         S_DIVB: begin
            if (div_done) begin
               b_ff    <= BW'(div_res);
               bout_ff <= 8'(div_res);
            end
         end
         S_BUCK: begin
            c_ff    <= bcnt;
            bm_ff   <= bq_ff[31:16];
            bd_ff   <= bq_ff[47:32];
            base_ff <= bq_ff[BMW-1:48];
            if (op_ff != OP_COUNT && bcnt == '0) status_ff <= ST_EMPTY;
         end
         S_MUL2: begin
            prod_ff <= PW'(bm_ff) * PW'(key_ff);
            sq_ff   <= 32'(c_ff) * 32'(c_ff);
         end
         S_DIVC:  if (div_done) v_ff <= div_res;
         S_DIVD: begin
            if (div_done) begin
               if (slot_sum >= SUMW'(SLOT_WORDS)) begin
                  status_ff <= ST_FULL;
               end else begin
                  slot_ff <= SW'(slot_sum);
                  sout_ff <= 12'(slot_sum);
               end
            end
         end
         S_SETCHK: begin
            bout_ff <= sel_ff;
            if (32'(sel_ff) >= 32'(eff)) status_ff <= ST_RANGE;
         end
         S_SETRD:  c_ff  <= bcnt;
         S_SETSQ:  sq_ff <= 32'(c_ff) * 32'(c_ff);
         S_SETWR: begin
            if (need_sum > 33'(SLOT_WORDS)) begin
               status_ff <= ST_FULL;
            end else if (c_ff == '0) begin
               status_ff <= ST_EMPTY;
            end else begin
               sout_ff <= 12'(nf_ff);
            end
         end
         default: ;
      endcase
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (state_ff == S_SLOT && pend_ff && out_free) begin
         rsp_tvalid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_SLOT && pend_ff && out_free) begin
         rsp_tdata_ff <= {2'b00, sqsum_ff, sout_ff, bout_ff, coll_c, hit_c};
         rsp_tuser_ff <= status_ff;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

`ifndef SYNTHESIS
   a_nf_bound: assert property (@(posedge clock) disable iff (reset)
      32'(nf_ff) <= SLOT_WORDS)
      else $error("free pointer beyond slot store");

   a_div_done_state: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == S_DIVA || state_ff == S_DIVB ||
                    state_ff == S_DIVC || state_ff == S_DIVD))
      else $error("remainder finished outside a divide step");

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> state_ff != S_IDLE)
      else $error("request accepted without starting work");

   a_single_write: assert property (@(posedge clock) disable iff (reset)
      (bwe && state_ff != S_SWEEP) |-> !swe)
      else $error("bucket and slot written by one request at once");
`endif

endmodule

### tb/sv/tb_two_level_perfect_hash_table_top.sv
// Testbench for two_level_perfect_hash_table_top: directed table, a bucket-fill case, then FKS build phases
// (count, set, insert with re-set on collision, lookup) checked against a built-in predictor.
// Depends on tlph_pkg and the RTL of the block.
module tb_two_level_perfect_hash_table_top;
   import tlph_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NB = MAX_BUCKETS_DEF;
   localparam int NS = SLOT_WORDS_DEF;
   localparam int WATCHDOG = 20000;

   typedef struct packed {
      logic        hit;
      logic        coll;
      logic [7:0]  bucket;
      logic [11:0] slot;
      logic [31:0] squares;
      logic [1:0]  status;
   } hash_rsp_t;

   typedef struct {
      bit          cfg;
      logic [2:0]  op;
      logic [15:0] key;
      logic [7:0]  sel;
      logic [15:0] m2;
      logic [15:0] md2;
      bit          typed;
      hash_rsp_t   res;
   } dir_row_t;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [55:0] req_tdata = '0;
   logic [2:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [55:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        csr_we = 0;
   logic [1:0]  csr_index = '0;
   logic [15:0] csr_wdata = '0;

   two_level_perfect_hash_table_top uut (.*);

   always #5 clock = ~clock;

   // predictor state
   logic [15:0] p_mult1, p_mod1;
   logic [8:0]  p_total;
   logic [15:0] p_count [NB];
   logic [15:0] p_mult2 [NB];
   logic [15:0] p_mod2  [NB];
   logic [12:0] p_base  [NB];
   bit          p_coef_set [NB];
   logic [12:0] p_next_free;
   logic [31:0] p_squares;
   logic [15:0] p_slot_key [NS];
   bit          p_slot_valid [NS];

   hash_rsp_t   hash_pending [$];
   int          mismatches = 0;
   bit          calm = 0;
   bit          hold_request = 0;
   int          quiet_cycles = 0;

   function automatic int eff_total();
      return (p_total == 0 || p_total > NB) ? NB : int'(p_total);
   endfunction

   function automatic int bucket_of(logic [15:0] k);
      longint v;
      v = longint'(p_mult1) * k;
      if (p_mod1 != 0) v = v % p_mod1;
      return int'(v % eff_total());
   endfunction

   function automatic hash_rsp_t predict_hash(logic [2:0] op, logic [15:0] k, logic [7:0] sel,
                                              logic [15:0] m2, logic [15:0] md2);
      hash_rsp_t r;
      int        b;
      longint    c, v, need;
      r = '0;
      case (op)
         OP_CLEAR: begin
            foreach (p_count[i]) p_count[i] = 0;
            foreach (p_slot_valid[i]) p_slot_valid[i] = 0;
            p_next_free = 0;
            p_squares = 0;
         end
         OP_COUNT: begin
            b = bucket_of(k);
            r.bucket = 8'(b);
            c = p_count[b];
            if (c < 65535) begin
               p_count[b] = 16'(c + 1);
               v = longint'(p_squares) + 2 * c + 1;
               p_squares = v > 64'hFFFF_FFFF ? 32'hFFFF_FFFF : v[31:0];
            end
         end
         OP_SET: begin
            r.bucket = sel;
            if (sel >= eff_total()) begin
               r.status = ST_RANGE;
            end else begin
               c = p_count[sel];
               need = c * c;
               if (longint'(p_next_free) + need > NS) begin
                  r.status = ST_FULL;
               end else begin
                  p_mult2[sel] = m2;
                  p_mod2[sel] = md2;
                  p_base[sel] = p_next_free;
                  p_coef_set[sel] = 1;
                  if (c == 0) begin
                     r.status = ST_EMPTY;
                  end else begin
                     r.slot = p_next_free[11:0];
                     p_next_free = 13'(longint'(p_next_free) + need);
                  end
               end
            end
         end
         OP_INSERT, OP_LOOKUP: begin
            b = bucket_of(k);
            r.bucket = 8'(b);
            c = p_count[b];
            if (c == 0) begin
               r.status = ST_EMPTY;
            end else begin
               v = longint'(p_mult2[b]) * k;
               if (p_mod2[b] != 0) v = v % p_mod2[b];
               v = v % (c * c) + p_base[b];
               if (v >= NS) begin
                  r.status = ST_FULL;
               end else begin
                  r.slot = v[11:0];
                  if (op == OP_INSERT) begin
                     r.coll = p_slot_valid[v] && p_slot_key[v] != k;
                     p_slot_key[v] = k;
                     p_slot_valid[v] = 1;
                  end else begin
                     r.hit = p_slot_valid[v] && p_slot_key[v] == k;
                  end
               end
            end
         end
         default: ;
      endcase
      r.squares = p_squares;
      return r;
   endfunction

   task automatic send_request(logic [2:0] op, logic [15:0] k, logic [7:0] sel,
                               logic [15:0] m2, logic [15:0] md2,
                               bit typed = 0, hash_rsp_t typed_res = '0);
      hash_rsp_t r;
      int        b;
      if (op == OP_INSERT || op == OP_LOOKUP) begin
         b = bucket_of(k);
         if (p_count[b] != 0 && !p_coef_set[b]) op = 3'd7;
      end
      r = predict_hash(op, k, sel, m2, md2);
      hash_pending.push_back(typed ? typed_res : r);
      if (!calm && $urandom_range(99) < 31) begin
         req_tvalid <= 0;
         repeat ($urandom_range(4, 1)) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tuser <= op;
      req_tdata <= {md2, m2, sel, k};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic drain();
      req_tvalid <= 0;
      wait (hash_pending.size() == 0);
      repeat (200) @(posedge clock);
   endtask

   task automatic apply_config(logic [15:0] m1, logic [15:0] md1, logic [15:0] tot);
      csr_we <= 1; csr_index <= CSR_FIRST_MULT; csr_wdata <= m1;
      @(posedge clock);
      csr_index <= CSR_FIRST_MOD; csr_wdata <= md1;
      @(posedge clock);
      csr_index <= CSR_BUCKET_TOTAL; csr_wdata <= tot;
      @(posedge clock);
      csr_we <= 0;
      p_mult1 = m1;
      p_mod1 = md1;
      p_total = tot[8:0];
   endtask

   // receiver
   always @(posedge clock) begin : rsp_side
      hash_rsp_t got, want;
      int        hold;
      if (reset) begin
         hold = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = {rsp_tdata[0], rsp_tdata[1], rsp_tdata[9:2], rsp_tdata[21:10],
                   rsp_tdata[53:22], rsp_tuser};
            if (hash_pending.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected result %h", got);
            end else begin
               want = hash_pending.pop_front();
               if (got !== want || rsp_tdata[55:54] !== 2'b00) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: exp hit=%0d coll=%0d bkt=%0d slot=%0d sq=%0d st=%0d",
                              want.hit, want.coll, want.bucket, want.slot, want.squares,
                              want.status, "  got hit=%0d coll=%0d bkt=%0d slot=%0d sq=%0d st=%0d",
                              got.hit, got.coll, got.bucket, got.slot, got.squares,
                              got.status);
               end
            end
         end
         if (hold_request) begin
            hold_request = 0;
            hold = 400;
         end
         if (hold > 0) begin
            hold--;
            rsp_tready <= 0;
         end else begin
            rsp_tready <= calm || $urandom_range(99) >= 31;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > WATCHDOG) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   function automatic dir_row_t mk(bit cfg, logic [2:0] op, logic [15:0] k, logic [7:0] sel,
                                   logic [15:0] m2, logic [15:0] md2, bit typed = 0,
                                   hash_rsp_t res = '0);
      dir_row_t d;
      d.cfg = cfg; d.op = op; d.key = k; d.sel = sel; d.m2 = m2; d.md2 = md2;
      d.typed = typed; d.res = res;
      return d;
   endfunction

   task automatic build_phase(int n_keys, bit long_hold);
      logic [15:0] keys [$];
      int          collided [$];
      int          b;
      hash_rsp_t   r;
      logic [15:0] k;
      send_request(OP_CLEAR, 16'($urandom), 8'($urandom), 16'($urandom), 16'($urandom));
      repeat (n_keys) begin
         k = 16'($urandom);
         keys.push_back(k);
         send_request(OP_COUNT, k, 8'($urandom), 16'($urandom), 16'($urandom));
      end
      for (int i = 0; i < eff_total() && i < NB; i++)
         if (p_count[i] != 0 || $urandom_range(15) == 0)
            send_request(OP_SET, 16'($urandom), 8'(i), 16'($urandom), 16'($urandom));
      send_request(OP_SET, 16'($urandom), 8'($urandom), 16'($urandom), 16'($urandom));
      for (int round = 0; round < 3; round++) begin
         collided.delete();
         foreach (keys[i]) begin
            b = bucket_of(keys[i]);
            if (round == 0 || b inside {collided}) begin
               send_request(OP_INSERT, keys[i], 8'($urandom), 16'($urandom), 16'($urandom));
               r = hash_pending[$];
               if (r.coll && !(b inside {collided})) collided.push_back(b);
            end
         end
         foreach (collided[i])
            send_request(OP_SET, 16'($urandom), 8'(collided[i]), 16'($urandom),
                         16'($urandom));
         if (collided.size() == 0) break;
      end
      if (long_hold) hold_request = 1;
      repeat (n_keys * 2) begin
         case ($urandom_range(9))
            0: send_request(OP_COUNT, 16'($urandom), 8'($urandom), 16'($urandom),
                            16'($urandom));
            1: send_request(3'($urandom_range(7, 5)), 16'($urandom), 8'($urandom),
                            16'($urandom), 16'($urandom));
            2: send_request(OP_LOOKUP, 16'($urandom), 8'($urandom), 16'($urandom),
                            16'($urandom));
            3: send_request(OP_INSERT, keys[$urandom_range(keys.size() - 1)], 8'($urandom),
                            16'($urandom), 16'($urandom));
            default: send_request(OP_LOOKUP, keys[$urandom_range(keys.size() - 1)],
                                  8'($urandom), 16'($urandom), 16'($urandom));
         endcase
      end
   endtask

   initial begin
      dir_row_t    dir [$];
      logic [15:0] tot_pick [8] = '{1, 2, 3, 8, 16, 0, 300, 511};
      logic [15:0] m1, md1;

      p_mult1 = 1; p_mod1 = 1; p_total = 256;
      foreach (p_count[i]) begin
         p_count[i] = 0; p_mult2[i] = 0; p_mod2[i] = 0; p_base[i] = 0; p_coef_set[i] = 0;
      end
      foreach (p_slot_key[i]) begin
         p_slot_key[i] = 0; p_slot_valid[i] = 0;
      end
      p_next_free = 0;
      p_squares = 0;

      dir.push_back(mk(0, OP_LOOKUP, 16'h0000, 0, 0, 0, 1, '{0, 0, 0, 0, 0, ST_EMPTY}));
      dir.push_back(mk(0, OP_SET, 16'h0000, 255, 1, 1, 1, '{0, 0, 255, 0, 0, ST_EMPTY}));
      dir.push_back(mk(0, 3'd5, 16'hFFFF, 255, 16'hFFFF, 16'hFFFF, 1, '0));
      dir.push_back(mk(0, 3'd6, 16'hFFFF, 255, 16'hFFFF, 16'hFFFF, 1, '0));
      dir.push_back(mk(0, 3'd7, 16'hFFFF, 255, 16'hFFFF, 16'hFFFF, 1, '0));
      dir.push_back(mk(0, OP_COUNT, 16'hFFFF, 0, 0, 0, 1, '{0, 0, 0, 0, 1, ST_OK}));
      dir.push_back(mk(0, OP_COUNT, 16'h0000, 0, 0, 0, 1, '{0, 0, 0, 0, 4, ST_OK}));
      dir.push_back(mk(0, OP_SET, 0, 0, 16'hFFFF, 16'hFFFF));
      dir.push_back(mk(0, OP_INSERT, 16'hFFFF, 0, 0, 0));
      dir.push_back(mk(0, OP_INSERT, 16'h0000, 0, 0, 0));
      dir.push_back(mk(0, OP_INSERT, 16'h0001, 0, 0, 0));
      dir.push_back(mk(0, OP_LOOKUP, 16'hFFFF, 0, 0, 0));
      dir.push_back(mk(0, OP_LOOKUP, 16'h0000, 0, 0, 0));
      dir.push_back(mk(0, OP_LOOKUP, 16'h1234, 0, 0, 0));
      dir.push_back(mk(0, OP_SET, 0, 0, 7, 0));
      dir.push_back(mk(0, OP_INSERT, 16'h0005, 0, 0, 0));
      dir.push_back(mk(0, OP_LOOKUP, 16'h0005, 0, 0, 0));
      dir.push_back(mk(0, OP_CLEAR, 0, 0, 0, 0, 1, '0));
      dir.push_back(mk(1, 0, 4, 0, 16'hFFFF, 16'hFFFF));
      dir.push_back(mk(0, OP_SET, 0, 200, 1, 1, 1, '{0, 0, 200, 0, 0, ST_RANGE}));
      dir.push_back(mk(0, OP_SET, 0, 3, 1, 1, 1, '{0, 0, 3, 0, 0, ST_EMPTY}));
      dir.push_back(mk(1, 0, 0, 0, 1, 0));
      dir.push_back(mk(0, OP_COUNT, 16'd300, 0, 0, 0));
      dir.push_back(mk(0, OP_SET, 0, 8'd255, 1, 1));

      repeat (10) @(posedge clock);
      reset <= 0;

      foreach (dir[i]) begin
         if (dir[i].cfg) begin
            drain();
            apply_config(dir[i].m2, dir[i].md2, dir[i].key);
         end else begin
            send_request(dir[i].op, dir[i].key, dir[i].sel, dir[i].m2, dir[i].md2,
                         dir[i].typed, dir[i].res);
         end
      end

      // fill bucket 0 to exactly the whole store, then grow it past the end
      drain();
      apply_config(1, 1, 256);
      send_request(OP_CLEAR, 0, 0, 0, 0);
      for (int i = 0; i < 64; i++) send_request(OP_COUNT, 16'(i * 977), 0, 0, 0);
      send_request(OP_SET, 0, 0, 16'd40503, 16'd0);
      send_request(OP_COUNT, 16'hABCD, 0, 0, 0);
      for (int i = 0; i < 64; i++) send_request(OP_INSERT, 16'(i * 977), 0, 0, 0);
      send_request(OP_LOOKUP, 16'hABCD, 0, 0, 0);
      send_request(OP_SET, 0, 0, 3, 5);

      for (int ph = 0; ph < 14; ph++) begin
         drain();
         calm = (ph == 3);
         case (ph % 4)
            0: begin m1 = 16'($urandom); md1 = 16'($urandom_range(65535, 1)); end
            1: begin m1 = 16'hFFFF; md1 = 16'hFFFF; end
            2: begin m1 = 16'($urandom); md1 = 16'd0; end
            default: begin m1 = 16'($urandom_range(65535)); md1 = 16'd1; end
         endcase
         apply_config(m1, md1, tot_pick[$urandom_range(7)]);
         build_phase($urandom_range(40, 4), ph == 2);
      end

      drain();
      if (mismatches == 0) $display("ALL CHECKS PASSED");
      else $display("CHECKS FAILED");
      $finish;
   end
endmodule
